>>> rtl/core/pba_pkg.sv
package pba_pkg;

    localparam int PAGE_COUNT      = 16;
    localparam int BLOCKS_PER_PAGE = 64;
    localparam int BLOCK_BYTES     = 64;
    localparam int PAGE_BYTES      = 4096;
    localparam int RESERVED_BLOCKS = 3;

    localparam int ADDR_W      = 32;
    localparam int PG_W        = $clog2(PAGE_COUNT);
    localparam int PGN_W       = $clog2(PAGE_COUNT + 1);
    localparam int BLK_W       = $clog2(BLOCKS_PER_PAGE);
    localparam int CNT_W       = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int OFFB_W      = PAGE_SHIFT - BLOCK_SHIFT;
    localparam int PGF_W       = ADDR_W - PAGE_SHIFT;
    localparam int MEM_DEPTH   = 2 ** (PG_W + BLK_W);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic latch_in;
        logic decode;
        logic search_rd;
        logic fill_start;
        logic fill_step;
        logic alloc_fin;
        logic free_rd;
        logic free_fin;
        logic emit_oom;
        logic emit_bad;
    } t_ctl;

    typedef struct packed {
        logic is_free;
        logic found;
        logic pages_full;
        logic fill_last;
        logic bad;
        logic taken;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/pba_ram.sv
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pba_ctrl.sv
module pba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pba_pkg::t_sts i_sts,
    output pba_pkg::t_ctl o_ctl
);

    import pba_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECODE    = 8'b0000_0010,
        S_FREE_RD   = 8'b0000_0100,
        S_FREE_FIN  = 8'b0000_1000,
        S_SEARCH    = 8'b0001_0000,
        S_FILL      = 8'b0010_0000,
        S_ALLOC_FIN = 8'b0100_0000,
        S_SPARE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch_in = 1'b1;
                    n_state = i_sts.is_free ? S_DECODE : S_SEARCH;
                end
            end
            S_DECODE: begin
                o_ctl.decode = 1'b1;
                n_state = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (!i_sts.bad) begin
                    o_ctl.free_rd = 1'b1;
                    n_state = S_FREE_FIN;
                end else if (i_sts.out_free) begin
                    o_ctl.emit_bad = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FREE_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.free_fin = i_sts.taken;
                    o_ctl.emit_bad = !i_sts.taken;
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (i_sts.found) begin
                    o_ctl.search_rd = 1'b1;
                    n_state = S_ALLOC_FIN;
                end else if (!i_sts.pages_full) begin
                    o_ctl.fill_start = 1'b1;
                    n_state = S_FILL;
                end else if (i_sts.out_free) begin
                    o_ctl.emit_oom = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                o_ctl.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_SEARCH;
                end
            end
            S_ALLOC_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.alloc_fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/pba_datapath.sv
module pba_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pba_pkg::t_in_word          i_in_word,
    input  logic                       i_cfg_valid,
    input  logic [pba_pkg::ADDR_W-1:0] i_cfg_data,
    input  pba_pkg::t_ctl              i_ctl,
    output pba_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pba_pkg::t_out_word         o_out_word
);

    import pba_pkg::*;

    logic [ADDR_W-1:0] r_base;
    t_in_word          r_in;
    logic [PG_W-1:0]   r_pg;
    logic [BLK_W-1:0]  r_blk;
    logic              r_bad;
    logic [PGN_W-1:0]  r_pages;
    logic [BLK_W-1:0]  r_head [PAGE_COUNT];
    logic [CNT_W-1:0]  r_count [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_has_free;
    logic [BLK_W-1:0]  r_fill;
    t_out_word         r_out;
    logic              r_out_valid;

    logic              found;
    logic [PG_W-1:0]   sel_pg;
    logic [ADDR_W-1:0] off;
    logic [PGF_W-1:0]  off_pg;
    logic [OFFB_W-1:0] off_blk;
    logic              dec_bad;
    logic [CNT_W:0]    tail_sum;
    logic [BLK_W-1:0]  tail;
    logic [BLK_W-1:0]  alloc_blk;
    logic [ADDR_W-1:0] alloc_addr;
    logic              out_free;

    logic                      ring_we;
    logic [PG_W+BLK_W-1:0]     ring_waddr;
    logic [BLK_W-1:0]          ring_wdata;
    logic [PG_W+BLK_W-1:0]     ring_raddr;
    logic                      taken_we;
    logic [PG_W+BLK_W-1:0]     taken_waddr;
    logic                      taken_wdata;
    logic [PG_W+BLK_W-1:0]     taken_raddr;
    logic                      taken_rdata;

    always_comb begin
        found  = 1'b0;
        sel_pg = '0;
        for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
            if (r_has_free[p] && (PGN_W'(p) < r_pages)) begin
                found  = 1'b1;
                sel_pg = PG_W'(p);
            end
        end
    end

    assign off     = r_in.address - r_base;
    assign off_pg  = off[ADDR_W-1:PAGE_SHIFT];
    assign off_blk = off[PAGE_SHIFT-1:BLOCK_SHIFT];
    assign dec_bad = (off_pg >= PGF_W'(r_pages))
                   || ((OFFB_W+1)'(off_blk) >= (OFFB_W+1)'(BLOCKS_PER_PAGE))
                   || (off_blk < OFFB_W'(RESERVED_BLOCKS));

    assign tail_sum = (CNT_W+1)'(r_head[r_pg]) + (CNT_W+1)'(r_count[r_pg]);
    assign tail     = (tail_sum >= (CNT_W+1)'(BLOCKS_PER_PAGE))
                    ? BLK_W'(tail_sum - (CNT_W+1)'(BLOCKS_PER_PAGE))
                    : BLK_W'(tail_sum);

    assign alloc_addr = r_base + (ADDR_W'(r_pg) << PAGE_SHIFT)
                      + (ADDR_W'(alloc_blk) << BLOCK_SHIFT);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        ring_we     = 1'b0;
        ring_waddr  = {r_pg, tail};
        ring_wdata  = r_blk;
        taken_we    = 1'b0;
        taken_waddr = {r_pg, r_blk};
        taken_wdata = 1'b0;
        if (i_ctl.fill_step) begin
            ring_we     = (r_fill >= BLK_W'(RESERVED_BLOCKS));
            ring_waddr  = {r_pg, BLK_W'(r_fill - BLK_W'(RESERVED_BLOCKS))};
            ring_wdata  = r_fill;
            taken_we    = 1'b1;
            taken_waddr = {r_pg, r_fill};
            taken_wdata = (r_fill < BLK_W'(RESERVED_BLOCKS));
        end else if (i_ctl.alloc_fin) begin
            taken_we    = 1'b1;
            taken_waddr = {r_pg, alloc_blk};
            taken_wdata = 1'b1;
        end else if (i_ctl.free_fin) begin
            ring_we     = 1'b1;
            taken_we    = 1'b1;
        end
    end

    assign ring_raddr  = {sel_pg, r_head[sel_pg]};
    assign taken_raddr = {r_pg, r_blk};

    pba_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MEM_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (i_ctl.search_rd),
        .i_raddr (ring_raddr),
        .o_rdata (alloc_blk)
    );

    pba_ram #(
        .WIDTH (1),
        .DEPTH (MEM_DEPTH)
    ) u_taken (
        .i_clk   (i_clk),
        .i_we    (taken_we),
        .i_waddr (taken_waddr),
        .i_wdata (taken_wdata),
        .i_re    (i_ctl.free_rd),
        .i_raddr (taken_raddr),
        .o_rdata (taken_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_pages     <= '0;
            r_has_free  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_ctl.fill_step && (r_fill == BLK_W'(BLOCKS_PER_PAGE - 1))) begin
                r_pages          <= r_pages + PGN_W'(1);
                r_has_free[r_pg] <= 1'b1;
            end
            if (i_ctl.alloc_fin) begin
                r_has_free[r_pg] <= (r_count[r_pg] != CNT_W'(1));
            end
            if (i_ctl.free_fin) begin
                r_has_free[r_pg] <= 1'b1;
            end
            if (i_ctl.alloc_fin || i_ctl.free_fin || i_ctl.emit_oom || i_ctl.emit_bad) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_in <= i_in_word;
        end
        if (i_ctl.decode) begin
            r_pg  <= PG_W'(off_pg);
            r_blk <= BLK_W'(off_blk);
            r_bad <= dec_bad;
        end
        if (i_ctl.search_rd) begin
            r_pg <= sel_pg;
        end
        if (i_ctl.fill_start) begin
            r_pg   <= PG_W'(r_pages);
            r_fill <= '0;
        end
        if (i_ctl.fill_step) begin
            r_fill <= r_fill + BLK_W'(1);
            if (r_fill == BLK_W'(BLOCKS_PER_PAGE - 1)) begin
                r_head[r_pg]  <= '0;
                r_count[r_pg] <= CNT_W'(BLOCKS_PER_PAGE - RESERVED_BLOCKS);
            end
        end
        if (i_ctl.alloc_fin) begin
            r_head[r_pg]  <= (r_head[r_pg] == BLK_W'(BLOCKS_PER_PAGE - 1))
                           ? '0 : r_head[r_pg] + BLK_W'(1);
            r_count[r_pg] <= r_count[r_pg] - CNT_W'(1);
            r_out.block_address <= alloc_addr;
            r_out.status        <= ST_OK;
        end
        if (i_ctl.free_fin) begin
            r_count[r_pg]       <= r_count[r_pg] + CNT_W'(1);
            r_out.block_address <= '0;
            r_out.status        <= ST_OK;
        end
        if (i_ctl.emit_oom) begin
            r_out.block_address <= '0;
            r_out.status        <= ST_OOM;
        end
        if (i_ctl.emit_bad) begin
            r_out.block_address <= '0;
            r_out.status        <= ST_BAD;
        end
    end

    assign o_sts.is_free    = (i_in_word.cmd == CMD_FREE);
    assign o_sts.found      = found;
    assign o_sts.pages_full = (r_pages == PGN_W'(PAGE_COUNT));
    assign o_sts.fill_last  = (r_fill == BLK_W'(BLOCKS_PER_PAGE - 1));
    assign o_sts.bad        = r_bad;
    assign o_sts.taken      = taken_rdata;
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> rtl/core/paged_block_allocator_top.sv
// Allocate: search, ring read, result; a new page is first filled (a start step, then
// a fill step per block, ring entries for unreserved ones). Out of memory: from search.
// Free: decode, taken-bit read, update; a bad range is reported instead of the read.
// One word in flight, next accepted once the result is registered; a full output stalls.
// Reset (synchronous, active low) clears the FSM, page count, base and output valid;
// block memories are not cleared.
module paged_block_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pba_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pba_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pba_pkg::ADDR_W-1:0] i_cfg_data
);

    import pba_pkg::*;

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    pba_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
